// ----- rtl/core/fpa_pkg.sv -----
// ---------------------------------------------------------------------------
// fpa_pkg
// shared types and constants for the fit policy partition allocator
// ---------------------------------------------------------------------------
package fpa_pkg;

  localparam int PARTITIONS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_BITS   = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int CNT_BITS   = $clog2(PARTITIONS + 1);

  // configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 5;
  localparam logic [CFG_IDX_BITS-1:0] REG_FIT_POLICY    = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PARTS_IN_USE  = 1'b1;

  // placement policy codes, the unused code behaves as first fit
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // request types
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_LOADED    = 2'd0;
  localparam logic [1:0] STAT_ALLOCATED = 2'd1;
  localparam logic [1:0] STAT_REFUSED   = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  partition_index;
    logic [15:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  granted_partition;
    logic [15:0] space_left;
    logic [15:0] request_number;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } fpa_state_t;

endpackage

// ----- rtl/core/fpa_ram.sv -----
// ---------------------------------------------------------------------------
// fpa_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module fpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/fit_policy_partition_allocator_core.sv -----
// ---------------------------------------------------------------------------
// fit_policy_partition_allocator_core
// partition free-space table with first, best and worst fit placement
// ---------------------------------------------------------------------------
// operation: a load is written into the table when accepted and its result
//   is registered in the finish state; an allocation scans the searched
//   partitions with one read of the free-space ram per cycle, then builds its
//   result in the finish state, which waits while the result register is
//   full; no new transaction is accepted until the block is back in idle
// reset (synchronous, rst_n low): fit first policy, 16 partitions searched,
//   request counter zero, no result pending; the table holds no defined data
//   until each partition is loaded
// ---------------------------------------------------------------------------
module fit_policy_partition_allocator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // input transactions
  input  logic                                in_valid,
  output logic                                in_ready,
  input  fpa_pkg::in_item_t                   in_data,
  // result transactions
  output logic                                out_valid,
  input  logic                                out_ready,
  output fpa_pkg::out_item_t                  out_data,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [fpa_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [fpa_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  // configuration registers
  logic [1:0]                       policy_r;
  logic [4:0]                       parts_r;

  // control state
  fpa_pkg::fpa_state_t              state_r, state_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [15:0]                      req_cnt_r, req_cnt_nxt;
  logic [fpa_pkg::CNT_BITS-1:0]     issue_cnt_r, issue_cnt_nxt;
  logic                             pend_r, pend_nxt;
  logic                             found_r, found_nxt;

  // payload
  fpa_pkg::in_item_t                item_r, item_nxt;
  fpa_pkg::out_item_t               out_data_r, out_data_nxt;
  logic [fpa_pkg::IDX_BITS-1:0]     pend_idx_r, pend_idx_nxt;
  logic [fpa_pkg::IDX_BITS-1:0]     pick_r, pick_nxt;
  logic [fpa_pkg::SIZE_BITS-1:0]    best_r, best_nxt;

  // ram port signals
  logic                             ram_we;
  logic [fpa_pkg::IDX_BITS-1:0]     ram_waddr;
  logic [fpa_pkg::SIZE_BITS-1:0]    ram_wdata;
  logic [fpa_pkg::IDX_BITS-1:0]     ram_raddr;
  logic [fpa_pkg::SIZE_BITS-1:0]    ram_rdata;

  // helpers
  logic [fpa_pkg::CNT_BITS-1:0]     limit;
  logic [fpa_pkg::SIZE_BITS-1:0]    in_amt;
  logic [fpa_pkg::SIZE_BITS-1:0]    item_amt;
  logic [fpa_pkg::SIZE_BITS-1:0]    remain;
  logic                             in_idx_ok;
  logic                             item_idx_ok;
  logic                             fits;
  logic                             take;
  logic                             out_free;

  fpa_ram #(
    .WIDTH (fpa_pkg::SIZE_BITS),
    .DEPTH (fpa_pkg::PARTITIONS)
  ) u_free_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration writes, the search count is clamped to the table size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= fpa_pkg::FIT_FIRST;
      parts_r  <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fpa_pkg::REG_FIT_POLICY:   policy_r <= cfg_wdata[1:0];
        fpa_pkg::REG_PARTS_IN_USE: parts_r  <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(parts_r) > fpa_pkg::PARTITIONS) begin
      limit = fpa_pkg::CNT_BITS'(fpa_pkg::PARTITIONS);
    end else begin
      limit = fpa_pkg::CNT_BITS'(parts_r);
    end
  end

  assign in_amt      = fpa_pkg::SIZE_BITS'(in_data.amount);
  assign item_amt    = fpa_pkg::SIZE_BITS'(item_r.amount);
  assign in_idx_ok   = 32'(in_data.partition_index) < fpa_pkg::PARTITIONS;
  assign item_idx_ok = 32'(item_r.partition_index) < fpa_pkg::PARTITIONS;
  assign remain      = best_r - item_amt;
  assign out_free    = !out_valid_r || out_ready;

  // compare of the entry read back last cycle against the best so far
  assign fits = ram_rdata >= item_amt;
  always_comb begin
    take = 1'b0;
    if (pend_r && fits) begin
      if (!found_r) begin
        take = 1'b1;
      end else if (policy_r == fpa_pkg::FIT_BEST && ram_rdata < best_r) begin
        take = 1'b1;
      end else if (policy_r == fpa_pkg::FIT_WORST && ram_rdata > best_r) begin
        take = 1'b1;
      end
    end
  end

  // state register and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      req_cnt_r   <= '0;
      issue_cnt_r <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      req_cnt_r   <= req_cnt_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
    pend_idx_r <= pend_idx_nxt;
    pick_r     <= pick_nxt;
    best_r     <= best_nxt;
  end

  // next state, ram control and result build
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    req_cnt_nxt   = req_cnt_r;
    issue_cnt_nxt = issue_cnt_r;
    pend_nxt      = pend_r;
    found_nxt     = found_r;
    item_nxt      = item_r;
    out_data_nxt  = out_data_r;
    pend_idx_nxt  = pend_idx_r;
    pick_nxt      = pick_r;
    best_nxt      = best_r;
    ram_we        = 1'b0;
    ram_waddr     = fpa_pkg::IDX_BITS'(in_data.partition_index);
    ram_wdata     = in_amt;
    ram_raddr     = issue_cnt_r[fpa_pkg::IDX_BITS-1:0];

    // result register empties when the consumer takes it
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      fpa_pkg::ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          if (in_data.req_type == fpa_pkg::REQ_LOAD) begin
            // loads go straight into the table, out of range ones are dropped
            ram_we    = in_idx_ok;
            state_nxt = fpa_pkg::ST_FINISH;
          end else begin
            req_cnt_nxt   = req_cnt_r + 16'd1;
            issue_cnt_nxt = '0;
            pend_nxt      = 1'b0;
            found_nxt     = 1'b0;
            state_nxt     = fpa_pkg::ST_SCAN;
          end
        end
      end

      fpa_pkg::ST_SCAN: begin
        // issue one read a cycle, compare the data of the previous read
        pend_nxt = 1'b0;
        if (issue_cnt_r < limit) begin
          pend_nxt      = 1'b1;
          pend_idx_nxt  = issue_cnt_r[fpa_pkg::IDX_BITS-1:0];
          issue_cnt_nxt = issue_cnt_r + fpa_pkg::CNT_BITS'(1);
        end
        if (take) begin
          found_nxt = 1'b1;
          pick_nxt  = pend_idx_r;
          best_nxt  = ram_rdata;
        end
        if (issue_cnt_r >= limit && !pend_r) begin
          state_nxt = fpa_pkg::ST_FINISH;
        end
      end

      fpa_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = fpa_pkg::ST_IDLE;
          if (item_r.req_type == fpa_pkg::REQ_LOAD) begin
            out_data_nxt.status            = fpa_pkg::STAT_LOADED;
            out_data_nxt.granted_partition = item_r.partition_index;
            out_data_nxt.space_left        = item_idx_ok ? 16'(item_amt) : 16'd0;
            out_data_nxt.request_number    = 16'd0;
          end else if (found_r) begin
            // write back the shrunk free size of the chosen partition
            ram_we    = 1'b1;
            ram_waddr = pick_r;
            ram_wdata = remain;
            out_data_nxt.status            = fpa_pkg::STAT_ALLOCATED;
            out_data_nxt.granted_partition = 4'(pick_r);
            out_data_nxt.space_left        = 16'(remain);
            out_data_nxt.request_number    = req_cnt_r;
          end else begin
            out_data_nxt.status            = fpa_pkg::STAT_REFUSED;
            out_data_nxt.granted_partition = 4'd0;
            out_data_nxt.space_left        = 16'd0;
            out_data_nxt.request_number    = req_cnt_r;
          end
        end
      end

      default: begin
        state_nxt = fpa_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == fpa_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- tb/fit_policy_partition_allocator_core_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fit_policy_partition_allocator_core_tb
// self-checking bench for the partition allocator: a directed table loads
// every partition and walks the placement policies and search-count corner
// cases, then random load and allocation traffic runs under a series of
// settings, each result checked against a behavioural copy of the table
// ---------------------------------------------------------------------------
module fit_policy_partition_allocator_core_tb;

  // code 3 is not a real policy, the block treats it as first fit
  localparam logic [1:0] FIT_UNUSED = 2'd3;

  // kinds of row in the directed table
  typedef enum logic {
    ROW_ITEM,
    ROW_SETUP
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    fpa_pkg::in_item_t  item;
    logic               fixed;   // expectation typed into the row
    fpa_pkg::out_item_t want;
    logic [1:0]         policy;  // settings for a setup row
    logic [4:0]         count;
  } step_t;

  // dut connections, all inputs known from time zero
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  fpa_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  fpa_pkg::out_item_t out_data;
  logic               cfg_we = 1'b0;
  logic [fpa_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [fpa_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // behavioural copy of the allocator state
  logic [15:0] free_space [fpa_pkg::PARTITIONS];
  logic [15:0] request_seq = '0;
  logic [1:0]  fit_mode = fpa_pkg::FIT_FIRST;
  logic [4:0]  search_count = 5'd16;

  // outcomes still owed by the block, oldest first
  fpa_pkg::out_item_t predicted_outcomes [$];

  // typed expectation travelling with the transaction on the input channel
  logic               row_fixed = 1'b0;
  fpa_pkg::out_item_t row_want = '0;

  step_t directed_steps [$];

  int mismatch_count = 0;
  int burst_left = 0;
  int loads_seen = 0;
  int placed_seen = 0;
  int refused_seen = 0;
  int settings_written = 0;

  // receiver stall pattern state
  int stall_mode = 0;
  int stall_span = 0;

  fit_policy_partition_allocator_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // prediction: a load sets one entry, a request scans the searched entries
  // and takes the first, smallest or largest that holds it, lowest index on
  // a tie; every request bumps the sequence number, placed or not
  // -------------------------------------------------------------------------
  function automatic fpa_pkg::out_item_t predict_placement(fpa_pkg::in_item_t it);
    fpa_pkg::out_item_t res;
    int                 reach;
    int                 pick;
    res = '0;
    if (it.req_type == fpa_pkg::REQ_LOAD) begin
      free_space[it.partition_index] = it.amount;
      res.status            = fpa_pkg::STAT_LOADED;
      res.granted_partition = it.partition_index;
      res.space_left        = it.amount;
      return res;
    end
    request_seq = request_seq + 16'd1;
    // search count above the table size is clamped, zero searches nothing
    reach = (search_count > fpa_pkg::PARTITIONS) ? fpa_pkg::PARTITIONS
                                                 : int'(search_count);
    pick = -1;
    for (int j = 0; j < reach; j++) begin
      if (free_space[j] < it.amount)
        continue;
      if (pick < 0) begin
        pick = j;
        // first fit and the unused code stop at the first candidate
        if (fit_mode != fpa_pkg::FIT_BEST && fit_mode != fpa_pkg::FIT_WORST)
          break;
      end else if (fit_mode == fpa_pkg::FIT_BEST &&
                   free_space[j] < free_space[pick]) begin
        pick = j;
      end else if (fit_mode == fpa_pkg::FIT_WORST &&
                   free_space[j] > free_space[pick]) begin
        pick = j;
      end
    end
    if (pick < 0) begin
      res.status = fpa_pkg::STAT_REFUSED;
    end else begin
      free_space[pick]      = free_space[pick] - it.amount;
      res.status            = fpa_pkg::STAT_ALLOCATED;
      res.granted_partition = 4'(pick);
      res.space_left        = free_space[pick];
    end
    res.request_number = request_seq;
    return res;
  endfunction

  // directed table rows
  function automatic step_t load_row(int idx, int amt);
    step_t r;
    r = '0;
    r.kind                   = ROW_ITEM;
    r.item.req_type          = fpa_pkg::REQ_LOAD;
    r.item.partition_index   = 4'(idx);
    r.item.amount            = 16'(amt);
    r.fixed                  = 1'b1;
    r.want.status            = fpa_pkg::STAT_LOADED;
    r.want.granted_partition = 4'(idx);
    r.want.space_left        = 16'(amt);
    return r;
  endfunction

  function automatic step_t ask_row(int amt);
    step_t r;
    r = '0;
    r.kind                 = ROW_ITEM;
    r.item.req_type        = fpa_pkg::REQ_ALLOC;
    r.item.partition_index = 4'hf;   // ignored on requests
    r.item.amount          = 16'(amt);
    return r;
  endfunction

  function automatic step_t ask_fixed(int amt, logic [1:0] st, int part, int left, int num);
    step_t r;
    r = ask_row(amt);
    r.fixed                  = 1'b1;
    r.want.status            = st;
    r.want.granted_partition = 4'(part);
    r.want.space_left        = 16'(left);
    r.want.request_number    = 16'(num);
    return r;
  endfunction

  function automatic step_t setup_row(logic [1:0] pol, int cnt);
    step_t r;
    r = '0;
    r.kind   = ROW_SETUP;
    r.policy = pol;
    r.count  = 5'(cnt);
    return r;
  endfunction

  // random traffic, shaped from the current table so that exact fits, near
  // misses and ties turn up often
  function automatic fpa_pkg::in_item_t random_request();
    fpa_pkg::in_item_t it;
    logic [15:0]       near;
    near = free_space[$urandom_range(0, fpa_pkg::PARTITIONS - 1)];
    it.partition_index = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < 35) begin
      it.req_type = fpa_pkg::REQ_LOAD;
      case ($urandom_range(0, 3))
        0:       it.amount = 16'($urandom_range(0, 65535));
        1:       it.amount = 16'($urandom_range(0, 255));
        2:       it.amount = near;                       // tie with another entry
        default: it.amount = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      endcase
    end else begin
      it.req_type = fpa_pkg::REQ_ALLOC;
      case ($urandom_range(0, 5))
        0:       it.amount = near;                       // exact fit
        1:       it.amount = near + 16'd1;               // just too big
        2:       it.amount = (near == 0) ? near : near - 16'd1;
        3:       it.amount = 16'($urandom_range(0, 64));
        4:       it.amount = 16'($urandom_range(0, 65535));
        default: it.amount = 16'h0000;                   // zero-size request
      endcase
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // sender: bursts of random length, random gaps between them; valid is only
  // lowered when a gap actually follows
  task automatic send_item(fpa_pkg::in_item_t it, logic fixed, fpa_pkg::out_item_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    in_data   <= it;
    row_fixed <= fixed;
    row_want  <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  // hold the sender off until every outstanding transaction has answered
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (predicted_outcomes.size() != 0) @(posedge clk);
  endtask

  // write both registers on back-to-back cycles; spare policy bits are noise
  task automatic write_regs(logic [1:0] pol, logic [4:0] cnt);
    cfg_we    <= 1'b1;
    cfg_index <= fpa_pkg::REG_FIT_POLICY;
    cfg_wdata <= {3'($urandom_range(0, 7)), pol};
    @(posedge clk);
    cfg_index <= fpa_pkg::REG_PARTS_IN_USE;
    cfg_wdata <= cnt;
    @(posedge clk);
    cfg_we   <= 1'b0;
    fit_mode     = pol;
    search_count = cnt;
    settings_written++;
  endtask

  // receiver: stretches of always-ready, coin-flip ready and long stalls
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(16, 80);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // input monitor: predict each accepted transaction
  always @(posedge clk) begin
    fpa_pkg::out_item_t r;
    if (rst_n && in_valid && in_ready) begin
      r = predict_placement(in_data);
      if (row_fixed)
        r = row_want;
      predicted_outcomes.push_back(r);
    end
  end

  // result checker: oldest expectation against each accepted result
  always @(posedge clk) begin
    fpa_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_outcomes.size() == 0) begin
        report_mismatch("result with nothing outstanding, status",
                        16'(out_data.status), 16'd0);
      end else begin
        want = predicted_outcomes.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", 16'(out_data.status), 16'(want.status));
        if (out_data.granted_partition !== want.granted_partition)
          report_mismatch("granted_partition", 16'(out_data.granted_partition),
                          16'(want.granted_partition));
        if (out_data.space_left !== want.space_left)
          report_mismatch("space_left", out_data.space_left, want.space_left);
        if (out_data.request_number !== want.request_number)
          report_mismatch("request_number", out_data.request_number, want.request_number);
        case (want.status)
          fpa_pkg::STAT_LOADED:    loads_seen++;
          fpa_pkg::STAT_ALLOCATED: placed_seen++;
          default:                 refused_seen++;
        endcase
      end
    end
  end

  // stimulus
  initial begin
    fpa_pkg::in_item_t it;
    logic [1:0]        pol;
    logic [4:0]        cnt;

    // every partition is loaded before the first search so no search ever
    // touches an entry that was never written
    directed_steps = '{
      load_row(0, 100),  load_row(1, 0),    load_row(2, 65535), load_row(3, 40),
      load_row(4, 300),  load_row(5, 40),   load_row(6, 65535), load_row(7, 500),
      load_row(8, 1000), load_row(9, 7),    load_row(10, 8),    load_row(11, 9),
      load_row(12, 10),  load_row(13, 11),  load_row(14, 12),   load_row(15, 4096),
      // reset settings: first fit over all sixteen
      ask_fixed(60, fpa_pkg::STAT_ALLOCATED, 0, 40, 1),
      ask_fixed(65535, fpa_pkg::STAT_ALLOCATED, 2, 0, 2),
      ask_fixed(0, fpa_pkg::STAT_ALLOCATED, 0, 40, 3),   // zero-size leaves it as is
      // best fit with a three-way tie at 40
      setup_row(fpa_pkg::FIT_BEST, 16),
      ask_row(40),
      ask_row(40),
      setup_row(fpa_pkg::FIT_WORST, 16),
      ask_row(1),
      // unused code falls back to first fit
      setup_row(FIT_UNUSED, 16),
      ask_row(200),
      // nothing searched, refused but still numbered
      setup_row(fpa_pkg::FIT_FIRST, 0),
      ask_fixed(0, fpa_pkg::STAT_REFUSED, 0, 0, 8),
      // oversized search count is clamped
      setup_row(fpa_pkg::FIT_BEST, 31),
      ask_row(65534),
      setup_row(fpa_pkg::FIT_WORST, 1),
      ask_row(101)
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[k]) begin
      if (directed_steps[k].kind == ROW_SETUP) begin
        settle();
        write_regs(directed_steps[k].policy, directed_steps[k].count);
      end else begin
        send_item(directed_steps[k].item, directed_steps[k].fixed, directed_steps[k].want);
      end
    end

    // random phases, each under its own settings, quiet block between them
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       begin pol = fpa_pkg::FIT_FIRST;  cnt = 5'd16; end
        1:       begin pol = fpa_pkg::FIT_BEST;   cnt = 5'd16; end
        2:       begin pol = fpa_pkg::FIT_WORST;  cnt = 5'd16; end
        3:       begin pol = FIT_UNUSED;          cnt = 5'd16; end
        4:       begin pol = fpa_pkg::FIT_BEST;   cnt = 5'd1;  end
        5:       begin pol = fpa_pkg::FIT_WORST;  cnt = 5'd0;  end
        6:       begin pol = fpa_pkg::FIT_FIRST;  cnt = 5'd31; end
        7:       begin pol = fpa_pkg::FIT_BEST;   cnt = 5'($urandom_range(2, 15)); end
        8:       begin pol = fpa_pkg::FIT_WORST;  cnt = 5'd17; end
        default: begin
          pol = 2'($urandom_range(0, 3));
          cnt = 5'($urandom_range(0, 31));
        end
      endcase
      settle();
      write_regs(pol, cnt);
      repeat (42) begin
        it = random_request();
        send_item(it, 1'b0, '0);
      end
    end

    // drain, then leave room for anything the block still pushes out
    settle();
    repeat (40) @(posedge clk);
    if (predicted_outcomes.size() != 0)
      report_mismatch("results never delivered", 16'(predicted_outcomes.size()), 16'd0);

    $display("covered %0d loads and %0d requests (%0d placed, %0d refused)",
             loads_seen, placed_seen + refused_seen, placed_seen, refused_seen);
    $display("%0d register settings applied: every policy code, searches of none, one,",
             settings_written);
    $display("part of the table, all of it and counts clamped above the table size");
    if (mismatch_count == 0) begin
      $display("fit_policy_partition_allocator_core_tb OK");
    end else begin
      $display("fit_policy_partition_allocator_core_tb NOT OK");
    end
    $finish;
  end

  // watchdog, many times the slowest legal run
  initial begin
    #5000000;
    $display("fit_policy_partition_allocator_core_tb NOT OK");
    $finish;
  end

endmodule
